// ===== rtl/dpa_pkg.sv =====
`default_nettype none
package dpa_pkg;

    localparam int OLD_DEPTH_DEF = 65536;

    localparam int NEW_SIZE_W = 31;
    localparam int OLD_SIZE_W = 17;
    localparam int CFG_W      = 31;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NEW_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OLD_SIZE = 1'd1;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_CTRL  = 2'd1;
    localparam logic [1:0] CMD_DIFF  = 2'd2;
    localparam logic [1:0] CMD_EXTRA = 2'd3;

    localparam logic [2:0] STAT_BYTE     = 3'd0;
    localparam logic [2:0] STAT_ACCEPTED = 3'd1;
    localparam logic [2:0] STAT_BAD_LEN  = 3'd2;
    localparam logic [2:0] STAT_BAD_SEEK = 3'd3;
    localparam logic [2:0] STAT_UNEXPECT = 3'd4;
    localparam logic [2:0] STAT_OVERFLOW = 3'd5;

    localparam logic [1:0] PH_CTRL = 2'd0;
    localparam logic [1:0] PH_ADD  = 2'd1;
    localparam logic [1:0] PH_COPY = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         data_byte;
        logic signed [31:0] add_length;
        logic signed [31:0] copy_length;
        logic signed [31:0] seek_offset;
    } t_in_item;

    typedef struct packed {
        logic [7:0] new_byte;
        logic [2:0] status;
        logic       done_res;
    } t_out_item;

    typedef struct packed {
        logic is_load;
        logic is_ctrl;
        logic is_diff;
        logic is_extra;
    } t_kind;

    typedef struct packed {
        t_kind    kind;
        t_in_item item;
    } t_front_item;

endpackage
`default_nettype wire

// ===== rtl/dpa_ram.sv =====
`default_nettype none
module dpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/dpa_front.sv =====
`default_nettype none
module dpa_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire dpa_pkg::t_in_item    i_item,
    output logic                      o_full,
    output logic                      o_valid,
    output dpa_pkg::t_front_item      o_item,
    input  wire logic                 i_take
);

    dpa_pkg::t_in_item r_mem [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_cnt;
    logic              push_ok;
    logic              take_ok;
    dpa_pkg::t_in_item head;

    assign push_ok = i_push && (r_cnt != 2'd2);
    assign take_ok = i_take && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wptr <= ~r_wptr;
            end
            if (take_ok) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(push_ok) - 2'(take_ok);
        end
    end

    assign head = r_mem[r_rptr];

    always_comb begin
        o_item.item = head;
        o_item.kind = '0;
        case (head.cmd)
            dpa_pkg::CMD_LOAD:  o_item.kind.is_load  = 1'b1;
            dpa_pkg::CMD_CTRL:  o_item.kind.is_ctrl  = 1'b1;
            dpa_pkg::CMD_DIFF:  o_item.kind.is_diff  = 1'b1;
            default:            o_item.kind.is_extra = 1'b1;
        endcase
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);

endmodule
`default_nettype wire

// ===== rtl/dpa_back.sv =====
`default_nettype none
module dpa_back #(
    parameter int OLD_DEPTH = dpa_pkg::OLD_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [dpa_pkg::NEW_SIZE_W-1:0]    i_new_size,
    input  wire logic [dpa_pkg::OLD_SIZE_W-1:0]    i_old_size,
    input  wire logic                              i_valid,
    input  wire dpa_pkg::t_front_item              i_item,
    output logic                                   o_take,
    output logic                                   o_empty,
    output dpa_pkg::t_out_item                     o_result,
    input  wire logic                              i_pop
);

    localparam int AW  = $clog2(OLD_DEPTH);
    localparam int LCW = $clog2(OLD_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0]           r_state,    n_state;
    dpa_pkg::t_front_item r_cur;
    logic [1:0]           r_phase,    n_phase;
    logic                 r_err,      n_err;
    logic [LCW-1:0]       r_load_cnt, n_load_cnt;
    logic [32:0]          r_old_pos,  n_old_pos;
    logic [30:0]          r_new_pos,  n_new_pos;
    logic [30:0]          r_add_rem,  n_add_rem;
    logic [30:0]          r_copy_rem, n_copy_rem;
    logic [16:0]          r_target,   n_target;
    logic [32:0]          r_len_sum,  n_len_sum;
    logic                 r_len_neg,  n_len_neg;
    logic [34:0]          r_tgt_sum,  n_tgt_sum;

    dpa_pkg::t_out_item   r_q [2];
    logic                 r_qw;
    logic                 r_qr;
    logic [1:0]           r_qcnt;

    logic                 res_push;
    dpa_pkg::t_out_item   res_item;
    logic                 pop_ok;
    logic                 ram_we;
    logic [7:0]           ram_q;
    logic                 diff_commit;
    logic [7:0]           diff_byte;
    logic                 done_now;
    logic                 addr_ok;
    dpa_pkg::t_in_item    cur;

    assign cur      = r_cur.item;
    assign done_now = (r_new_pos >= i_new_size);
    assign addr_ok  = (r_old_pos < {16'd0, i_old_size}) && (r_old_pos < 33'(OLD_DEPTH));

    dpa_ram #(
        .WIDTH (8),
        .DEPTH (OLD_DEPTH)
    ) u_old_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_load_cnt[AW-1:0]),
        .i_wdata (cur.data_byte),
        .i_raddr (r_old_pos[AW-1:0]),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_err       = r_err;
        n_load_cnt  = r_load_cnt;
        n_old_pos   = r_old_pos;
        n_new_pos   = r_new_pos;
        n_add_rem   = r_add_rem;
        n_copy_rem  = r_copy_rem;
        n_target    = r_target;
        n_len_sum   = r_len_sum;
        n_len_neg   = r_len_neg;
        n_tgt_sum   = r_tgt_sum;
        o_take      = 1'b0;
        ram_we      = 1'b0;
        res_push    = 1'b0;
        res_item    = '0;
        diff_commit = 1'b0;
        diff_byte   = cur.data_byte;

        case (r_state)
            S_IDLE: begin
                if (i_valid && (r_qcnt != 2'd2)) begin
                    o_take  = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (r_cur.kind.is_load) begin
                    res_push = 1'b1;
                    if (r_load_cnt < LCW'(OLD_DEPTH)) begin
                        ram_we          = 1'b1;
                        n_load_cnt      = r_load_cnt + LCW'(1);
                        res_item.status = dpa_pkg::STAT_ACCEPTED;
                    end else begin
                        res_item.status = dpa_pkg::STAT_OVERFLOW;
                    end
                end else if (r_err) begin
                    res_push        = 1'b1;
                    res_item.status = dpa_pkg::STAT_UNEXPECT;
                end else if (r_cur.kind.is_ctrl) begin
                    if ((r_phase != dpa_pkg::PH_CTRL) || done_now) begin
                        n_err           = 1'b1;
                        res_push        = 1'b1;
                        res_item.status = dpa_pkg::STAT_UNEXPECT;
                    end else begin
                        n_len_neg = cur.add_length[31] | cur.copy_length[31];
                        n_len_sum = {2'b00, r_new_pos} + {2'b00, cur.add_length[30:0]}
                                  + {2'b00, cur.copy_length[30:0]};
                        n_tgt_sum = {2'b00, r_old_pos}
                                  + {{3{cur.add_length[31]}}, cur.add_length}
                                  + {{3{cur.seek_offset[31]}}, cur.seek_offset};
                        n_state   = S_CHECK;
                    end
                end else if (r_cur.kind.is_diff) begin
                    if (r_phase != dpa_pkg::PH_ADD) begin
                        n_err           = 1'b1;
                        res_push        = 1'b1;
                        res_item.status = dpa_pkg::STAT_UNEXPECT;
                    end else if (addr_ok) begin
                        n_state = S_READ;
                    end else begin
                        diff_commit = 1'b1;
                    end
                end else begin
                    if (r_phase != dpa_pkg::PH_COPY) begin
                        n_err           = 1'b1;
                        res_push        = 1'b1;
                        res_item.status = dpa_pkg::STAT_UNEXPECT;
                    end else begin
                        res_push          = 1'b1;
                        res_item.status   = dpa_pkg::STAT_BYTE;
                        res_item.new_byte = cur.data_byte;
                        n_new_pos         = r_new_pos + 31'd1;
                        n_copy_rem        = r_copy_rem - 31'd1;
                        if (r_copy_rem == 31'd1) begin
                            n_old_pos = {16'd0, r_target};
                            n_phase   = dpa_pkg::PH_CTRL;
                        end
                    end
                end
            end
            S_READ: begin
                n_state     = S_IDLE;
                diff_commit = 1'b1;
                diff_byte   = cur.data_byte + ram_q;
            end
            default: begin
                n_state  = S_IDLE;
                res_push = 1'b1;
                if (r_len_neg || (r_len_sum > {2'b00, i_new_size})) begin
                    n_err           = 1'b1;
                    res_item.status = dpa_pkg::STAT_BAD_LEN;
                end else if (r_tgt_sum[34] || (r_tgt_sum > {18'd0, i_old_size})) begin
                    n_err           = 1'b1;
                    res_item.status = dpa_pkg::STAT_BAD_SEEK;
                end else begin
                    res_item.status = dpa_pkg::STAT_ACCEPTED;
                    n_add_rem       = cur.add_length[30:0];
                    n_copy_rem      = cur.copy_length[30:0];
                    n_target        = r_tgt_sum[16:0];
                    if (cur.add_length[30:0] != 31'd0) begin
                        n_phase = dpa_pkg::PH_ADD;
                    end else if (cur.copy_length[30:0] != 31'd0) begin
                        n_phase = dpa_pkg::PH_COPY;
                    end else begin
                        n_old_pos = {16'd0, r_tgt_sum[16:0]};
                        n_phase   = dpa_pkg::PH_CTRL;
                    end
                end
            end
        endcase

        if (diff_commit) begin
            res_push          = 1'b1;
            res_item.status   = dpa_pkg::STAT_BYTE;
            res_item.new_byte = diff_byte;
            n_new_pos         = r_new_pos + 31'd1;
            n_old_pos         = r_old_pos + 33'd1;
            n_add_rem         = r_add_rem - 31'd1;
            if (r_add_rem == 31'd1) begin
                if (r_copy_rem != 31'd0) begin
                    n_phase = dpa_pkg::PH_COPY;
                end else begin
                    n_old_pos = {16'd0, r_target};
                    n_phase   = dpa_pkg::PH_CTRL;
                end
            end
        end

        res_item.done_res = (n_new_pos >= i_new_size);
    end

    assign pop_ok = i_pop && (r_qcnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cur <= i_item;
        end
        if (res_push) begin
            r_q[r_qw] <= res_item;
        end
        r_len_sum <= n_len_sum;
        r_len_neg <= n_len_neg;
        r_tgt_sum <= n_tgt_sum;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= dpa_pkg::PH_CTRL;
            r_err      <= 1'b0;
            r_load_cnt <= '0;
            r_old_pos  <= '0;
            r_new_pos  <= '0;
            r_add_rem  <= '0;
            r_copy_rem <= '0;
            r_target   <= '0;
            r_qw       <= 1'b0;
            r_qr       <= 1'b0;
            r_qcnt     <= 2'd0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_err      <= n_err;
            r_load_cnt <= n_load_cnt;
            r_old_pos  <= n_old_pos;
            r_new_pos  <= n_new_pos;
            r_add_rem  <= n_add_rem;
            r_copy_rem <= n_copy_rem;
            r_target   <= n_target;
            if (res_push) begin
                r_qw <= ~r_qw;
            end
            if (pop_ok) begin
                r_qr <= ~r_qr;
            end
            r_qcnt <= r_qcnt + 2'(res_push) - 2'(pop_ok);
        end
    end

    assign o_empty  = (r_qcnt == 2'd0);
    assign o_result = r_q[r_qr];

endmodule
`default_nettype wire

// ===== rtl/delta_patch_apply.sv =====
// delta_patch_apply: applies an already decompressed bsdiff delta.
// Input queue: push/full with i_in_item (cmd, data_byte and control triple).
//   cmd 0 loads the next old-file byte, 1 is a control triple, 2 a diff byte,
//   3 an extra byte. Every accepted item yields exactly one result.
// Result queue: empty/pop with o_out_item (new_byte, status, done_res).
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 new_size,
//   1 old_size), a registered write; write only while no item is in flight.
// Flow: an idle executor takes one item, executes it and queues the result
//   for loads, extra bytes, diff bytes past the old data and rejected items;
//   diff bytes that read the old store pass a read state, control triples a
//   check state (two-step length/seek check). It handles one item at a time
//   and takes the next only when idle and the result queue has room.
// Both sides hold 2-entry queues; when results are not popped the executor
//   stops, the input queue fills and full rises. Nothing is dropped.
// Reset clears positions, phase, load count, error flag, registers and both
//   queues. The old store is not cleared and is valid only once loaded.
`default_nettype none
module delta_patch_apply #(
    parameter int OLD_DEPTH = dpa_pkg::OLD_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire dpa_pkg::t_in_item               i_in_item,
    output logic                                 empty,
    input  wire logic                            pop,
    output dpa_pkg::t_out_item                   o_out_item,
    input  wire logic                            i_cfg_we,
    input  wire logic [dpa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [dpa_pkg::CFG_W-1:0]       i_cfg_data
);

    logic [dpa_pkg::NEW_SIZE_W-1:0] r_new_size;
    logic [dpa_pkg::OLD_SIZE_W-1:0] r_old_size;
    logic                           front_valid;
    logic                           back_take;
    dpa_pkg::t_front_item           front_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_size <= '0;
            r_old_size <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpa_pkg::REG_NEW_SIZE: r_new_size <= i_cfg_data[dpa_pkg::NEW_SIZE_W-1:0];
                dpa_pkg::REG_OLD_SIZE: r_old_size <= i_cfg_data[dpa_pkg::OLD_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    dpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_in_item),
        .o_full  (full),
        .o_valid (front_valid),
        .o_item  (front_item),
        .i_take  (back_take)
    );

    dpa_back #(
        .OLD_DEPTH (OLD_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_new_size (r_new_size),
        .i_old_size (r_old_size),
        .i_valid    (front_valid),
        .i_item     (front_item),
        .o_take     (back_take),
        .o_empty    (empty),
        .o_result   (o_out_item),
        .i_pop      (pop)
    );

endmodule
`default_nettype wire

// ===== rtl/dpa_checker.sv =====
`default_nettype none
module dpa_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            push,
    input wire logic                            full,
    input wire logic                            empty,
    input wire logic                            pop,
    input wire dpa_pkg::t_out_item              o_out_item
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not clear after reset");

    a_no_spurious: assert property (@(posedge i_clk)
        !i_rst_n ##1 !push |=> empty)
        else $error("result without an input transfer");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_out_item.status != dpa_pkg::STAT_BYTE)) |->
            (o_out_item.new_byte == 8'd0))
        else $error("new_byte set on a non-byte status");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> $stable(o_out_item))
        else $error("result changed while stalled");

endmodule

bind delta_patch_apply dpa_checker u_dpa_checker (.*);
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;

    localparam int OLD_DEPTH = dpa_pkg::OLD_DEPTH_DEF;
    localparam int LIMIT     = 1_000_000;
    localparam int HOLD_CYC  = 200;

    typedef struct packed {
        bit                            is_cfg;
        logic [dpa_pkg::CFG_IDX_W-1:0] idx;
        logic [dpa_pkg::CFG_W-1:0]     val;
        dpa_pkg::t_in_item             item;
        bit                            typed;
        dpa_pkg::t_out_item            want;
    } t_step_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          push;
    logic                          full;
    dpa_pkg::t_in_item             i_in_item;
    logic                          empty;
    logic                          pop;
    dpa_pkg::t_out_item            o_out_item;
    logic                          i_cfg_we;
    logic [dpa_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [dpa_pkg::CFG_W-1:0]     i_cfg_data;

    delta_patch_apply dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // patch state mirror
    logic [7:0]  old_img [OLD_DEPTH];
    int unsigned load_cnt;
    longint      old_pos, new_pos, seek_pend, add_left, copy_left;
    longint      new_size_r, old_size_r;
    logic [1:0]  ph;
    bit          err_seen;

    dpa_pkg::t_out_item out_due_q[$];
    t_step_row          dir_rows[$];
    int                 snd_idle, rcv_idle;
    int                 mism;
    int                 n_pops;
    int                 cyc;
    bit                 hold_req;

    function automatic dpa_pkg::t_in_item mk_item(logic [1:0] cmd, logic [7:0] d,
                                                  logic [31:0] a, logic [31:0] c,
                                                  logic [31:0] s);
        dpa_pkg::t_in_item it;
        it.cmd         = cmd;
        it.data_byte   = d;
        it.add_length  = a;
        it.copy_length = c;
        it.seek_offset = s;
        return it;
    endfunction

    function automatic dpa_pkg::t_out_item res(logic [7:0] b, logic [2:0] st, logic dn);
        dpa_pkg::t_out_item r;
        r.new_byte = b;
        r.status   = st;
        r.done_res = dn;
        return r;
    endfunction

    function automatic t_step_row irow(dpa_pkg::t_in_item it, bit typed = 1'b0,
                                       dpa_pkg::t_out_item want = '0);
        t_step_row r;
        r = '0;
        r.item  = it;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic t_step_row crow(logic [dpa_pkg::CFG_IDX_W-1:0] idx,
                                       logic [dpa_pkg::CFG_W-1:0] val);
        t_step_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    task automatic apply_seek();
        old_pos   = old_pos + seek_pend;
        seek_pend = 0;
        ph        = dpa_pkg::PH_CTRL;
    endtask

    task automatic add_done();
        if (copy_left > 0) begin
            ph = dpa_pkg::PH_COPY;
        end else begin
            apply_seek();
        end
    endtask

    task automatic patch_step(input dpa_pkg::t_in_item it, output dpa_pkg::t_out_item r);
        longint a, c, s, tgt;
        bit     was_done;
        r = '0;
        was_done = new_pos >= new_size_r;
        a = $signed(it.add_length);
        c = $signed(it.copy_length);
        s = $signed(it.seek_offset);
        if (it.cmd == dpa_pkg::CMD_LOAD) begin
            if (load_cnt < OLD_DEPTH) begin
                old_img[load_cnt] = it.data_byte;
                load_cnt++;
                r.status = dpa_pkg::STAT_ACCEPTED;
            end else begin
                r.status = dpa_pkg::STAT_OVERFLOW;
            end
        end else if (err_seen) begin
            r.status = dpa_pkg::STAT_UNEXPECT;
        end else if (it.cmd == dpa_pkg::CMD_CTRL) begin
            tgt = old_pos + a + s;
            if (ph != dpa_pkg::PH_CTRL || was_done) begin
                r.status = dpa_pkg::STAT_UNEXPECT;
                err_seen = 1'b1;
            end else if (a < 0 || c < 0 || new_pos + a + c > new_size_r) begin
                r.status = dpa_pkg::STAT_BAD_LEN;
                err_seen = 1'b1;
            end else if (tgt < 0 || tgt > old_size_r) begin
                r.status = dpa_pkg::STAT_BAD_SEEK;
                err_seen = 1'b1;
            end else begin
                add_left  = a;
                copy_left = c;
                seek_pend = s;
                r.status  = dpa_pkg::STAT_ACCEPTED;
                if (a > 0) begin
                    ph = dpa_pkg::PH_ADD;
                end else begin
                    add_done();
                end
            end
        end else if (it.cmd == dpa_pkg::CMD_DIFF) begin
            if (ph != dpa_pkg::PH_ADD) begin
                r.status = dpa_pkg::STAT_UNEXPECT;
                err_seen = 1'b1;
            end else begin
                r.new_byte = it.data_byte;
                if (old_pos >= 0 && old_pos < old_size_r && old_pos < OLD_DEPTH) begin
                    r.new_byte = it.data_byte + old_img[int'(old_pos)];
                end
                r.status = dpa_pkg::STAT_BYTE;
                new_pos++;
                old_pos++;
                add_left--;
                if (add_left == 0) begin
                    add_done();
                end
            end
        end else begin
            if (ph != dpa_pkg::PH_COPY) begin
                r.status = dpa_pkg::STAT_UNEXPECT;
                err_seen = 1'b1;
            end else begin
                r.new_byte = it.data_byte;
                r.status   = dpa_pkg::STAT_BYTE;
                new_pos++;
                copy_left--;
                if (copy_left == 0) begin
                    apply_seek();
                end
            end
        end
        r.done_res = new_pos >= new_size_r;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mism++;
        if (mism <= 40) begin
            $display("MISMATCH %s: got %0h want %0h at result transfer %0d",
                     what, got, want, n_pops);
        end
    endtask

    task automatic check_result(input dpa_pkg::t_out_item got);
        dpa_pkg::t_out_item w;
        n_pops++;
        if (out_due_q.size() == 0) begin
            report("result with nothing due", 32'(got), 32'd0);
            return;
        end
        w = out_due_q.pop_front();
        if (got.new_byte !== w.new_byte) begin
            report("new_byte", 32'(got.new_byte), 32'(w.new_byte));
        end
        if (got.status !== w.status) begin
            report("status", 32'(got.status), 32'(w.status));
        end
        if (got.done_res !== w.done_res) begin
            report("done_res", 32'(got.done_res), 32'(w.done_res));
        end
    endtask

    task automatic send(input dpa_pkg::t_in_item it, input bit typed = 1'b0,
                        input dpa_pkg::t_out_item want = '0);
        dpa_pkg::t_out_item p;
        while ($urandom_range(99) < snd_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (full);
        patch_step(it, p);
        out_due_q.push_back(typed ? want : p);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (out_due_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [dpa_pkg::CFG_IDX_W-1:0] idx, input longint val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[dpa_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == dpa_pkg::REG_NEW_SIZE) begin
            new_size_r = val & 64'h7FFF_FFFF;
        end else begin
            old_size_r = val & 64'h1_FFFF;
        end
        @(posedge i_clk);
    endtask

    task automatic maybe_load();
        if ($urandom_range(9) == 0) begin
            send(mk_item(dpa_pkg::CMD_LOAD, 8'($urandom), $urandom, $urandom, $urandom));
        end
    endtask

    // well-formed patches with random content; budget is spent exactly
    task automatic patch_run(input longint nsz, input longint osz, input int budget,
                             input bit with_hold);
        int     a, c, left, n;
        longint t, sk;
        settle();
        write_reg(dpa_pkg::REG_NEW_SIZE, nsz);
        write_reg(dpa_pkg::REG_OLD_SIZE, osz);
        left = budget;
        n = 0;
        while (left > 0) begin
            a  = $urandom_range(0, left < 16 ? left : 16);
            c  = $urandom_range(0, (left - a) < 16 ? left - a : 16);
            t  = $urandom_range(0, int'(old_size_r));
            sk = t - old_pos - a;
            send(mk_item(dpa_pkg::CMD_CTRL, 8'($urandom), a, c, sk[31:0]));
            repeat (a) begin
                maybe_load();
                send(mk_item(dpa_pkg::CMD_DIFF, 8'($urandom), $urandom, $urandom, $urandom));
            end
            repeat (c) begin
                maybe_load();
                send(mk_item(dpa_pkg::CMD_EXTRA, 8'($urandom), $urandom, $urandom, $urandom));
            end
            left -= a + c;
            if (with_hold && n == 3) hold_req = 1'b1;
            n++;
        end
    endtask

    initial begin
        while (cyc < LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) check_result(o_out_item);
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
            end else if (i_rst_n) begin
                pop <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    initial begin
        longint   sk;
        int       kind;
        i_rst_n    <= 1'b0;
        push       <= 1'b0;
        i_in_item  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        load_cnt   = 0;
        old_pos    = 0;
        new_pos    = 0;
        seek_pend  = 0;
        add_left   = 0;
        copy_left  = 0;
        new_size_r = 0;
        old_size_r = 0;
        ph         = dpa_pkg::PH_CTRL;
        err_seen   = 1'b0;
        snd_idle   = 32;
        rcv_idle   = 53;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: loads with new_size still zero, then short hand-traced patches
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_LOAD, 8'h00, 0, 0, 0), 1,
                                res(0, dpa_pkg::STAT_ACCEPTED, 1)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_LOAD, 8'hFF, 0, 0, 0), 1,
                                res(0, dpa_pkg::STAT_ACCEPTED, 1)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_LOAD, 8'h80, 0, 0, 0)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_LOAD, 8'h01, 0, 0, 0)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_LOAD, 8'h55, 0, 0, 0)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_LOAD, 8'hAA, 0, 0, 0)));
        dir_rows.push_back(crow(dpa_pkg::REG_NEW_SIZE, 11));
        dir_rows.push_back(crow(dpa_pkg::REG_OLD_SIZE, 6));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_CTRL, 8'h00, 2, 2, 2), 1,
                                res(0, dpa_pkg::STAT_ACCEPTED, 0)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_DIFF, 8'hFF, 0, 0, 0), 1,
                                res(8'hFF, dpa_pkg::STAT_BYTE, 0)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_DIFF, 8'h01, 0, 0, 0), 1,
                                res(8'h00, dpa_pkg::STAT_BYTE, 0)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_EXTRA, 8'h00, 0, 0, 0), 1,
                                res(8'h00, dpa_pkg::STAT_BYTE, 0)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_EXTRA, 8'hFF, 0, 0, 0), 1,
                                res(8'hFF, dpa_pkg::STAT_BYTE, 0)));
        // zero add, seek lands exactly on old_size
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_CTRL, 8'h00, 0, 1, 2)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_EXTRA, 8'h3C, 0, 0, 0)));
        // diff bytes past the old data pass alone; zero copy seeks at once
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_CTRL, 8'h00, 2, 0, -2)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_DIFF, 8'h12, 0, 0, 0), 1,
                                res(8'h12, dpa_pkg::STAT_BYTE, 0)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_DIFF, 8'h34, 0, 0, 0)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_CTRL, 8'h00, 0, 0, -6)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_LOAD, 8'h5A, 0, 0, 0), 1,
                                res(0, dpa_pkg::STAT_ACCEPTED, 0)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_CTRL, 8'h00, 2, 2, 0)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_DIFF, 8'h00, 0, 0, 0)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_DIFF, 8'hFF, 0, 0, 0)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_EXTRA, 8'hA5, 0, 0, 0)));
        dir_rows.push_back(irow(mk_item(dpa_pkg::CMD_EXTRA, 8'h5A, 0, 0, 0), 1,
                                res(8'h5A, dpa_pkg::STAT_BYTE, 1)));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                settle();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end else begin
                send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        patch_run(new_pos + 130, load_cnt, 130, 1'b1);
        snd_idle = 53;
        rcv_idle = 32;
        patch_run(new_pos + 120, 0, 120, 1'b0);
        snd_idle = 0;
        rcv_idle = 0;
        patch_run(new_pos + 60, load_cnt, 60, 1'b0);

        // largest new size, old size covering every loaded byte
        patch_run(64'h7FFF_FFFF, load_cnt, 40, 1'b0);

        // one error sets the sticky flag; everything after but loads is rejected
        settle();
        kind = $urandom_range(0, 4);
        case (kind)
            0: begin
                send(mk_item(dpa_pkg::CMD_CTRL, 0, 32'h8000_0000, 0, 0), 1,
                     res(0, dpa_pkg::STAT_BAD_LEN, 0));
            end
            1: begin
                sk = -old_pos - 1;
                send(mk_item(dpa_pkg::CMD_CTRL, 0, 0, 0, sk[31:0]), 1,
                     res(0, dpa_pkg::STAT_BAD_SEEK, 0));
            end
            2: begin
                send(mk_item($urandom_range(0, 1) ? dpa_pkg::CMD_DIFF : dpa_pkg::CMD_EXTRA,
                             8'($urandom), 0, 0, 0),
                     1, res(0, dpa_pkg::STAT_UNEXPECT, 0));
            end
            3: begin
                write_reg(dpa_pkg::REG_NEW_SIZE, new_pos);
                send(mk_item(dpa_pkg::CMD_CTRL, 0, 0, 0, 0), 1,
                     res(0, dpa_pkg::STAT_UNEXPECT, 1));
            end
            default: begin
                send(mk_item(dpa_pkg::CMD_CTRL, 0, 1, 0, 0));
                send(mk_item(dpa_pkg::CMD_CTRL, 0, 0, 0, 0), 1,
                     res(0, dpa_pkg::STAT_UNEXPECT, 0));
            end
        endcase
        send(mk_item(dpa_pkg::CMD_CTRL, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        send(mk_item(dpa_pkg::CMD_CTRL, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        repeat (40) begin
            send(mk_item(2'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom,
                         $urandom));
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (mism == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== delta_patch_apply.f =====
rtl/dpa_pkg.sv
rtl/dpa_ram.sv
rtl/dpa_front.sv
rtl/dpa_back.sv
rtl/delta_patch_apply.sv
rtl/dpa_checker.sv
bench/tb.sv
